// ----- design/lps_pkg.sv -----
// Shared constants, types and helper functions of the LED pattern sequencer.
`timescale 1ns / 1ps

package lps_pkg;

  localparam int NUM_LEDS       = 4;
  localparam int NUM_BOARD_LEDS = 3;
  localparam int NUM_MODES      = 6;

  localparam int PERIOD_W    = 16;
  localparam int TICK_W      = 32;
  localparam int MODE_W      = 3;
  localparam int PAT_OUT_W   = 4;
  localparam int BOARD_OUT_W = 3;
  localparam int CFG_IDX_W   = 3;
  // step has to reach NUM_LEDS itself in streak mode
  localparam int STEP_W      = $clog2(NUM_LEDS + 1);
  localparam int MOD_W       = $clog2(NUM_LEDS);

  typedef enum logic [MODE_W-1:0] {
    MODE_SYNC   = 3'd0,
    MODE_CHASE  = 3'd1,
    MODE_BOUNCE = 3'd2,
    MODE_STREAK = 3'd3,
    MODE_ALARM  = 3'd4,
    MODE_RANDOM = 3'd5
  } mode_t;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_SYNC   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_CHASE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_BOUNCE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_STREAK = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_ALARM  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_RANDOM = 3'd5;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET [NUM_MODES] =
    '{16'd500, 16'd150, 16'd100, 16'd200, 16'd80, 16'd120};

  typedef struct packed {
    logic [STEP_W-1:0]   step;
    logic                fwd;
    logic [NUM_LEDS-1:0] pattern;
  } scene_state_t;

  // Single lit LED, nothing for an index past the last LED
  function automatic logic [NUM_LEDS-1:0] one_led(input logic [STEP_W-1:0] idx);
    logic [NUM_LEDS-1:0] r;
    r = '0;
    for (int i = 0; i < NUM_LEDS; i++) begin
      if (idx == STEP_W'(i)) begin
        r[i] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic [PAT_OUT_W-1:0] pattern_out(input logic [NUM_LEDS-1:0] p);
    logic [PAT_OUT_W-1:0] r;
    r = '0;
    for (int i = 0; i < PAT_OUT_W; i++) begin
      if (i < NUM_LEDS) begin
        r[i] = p[i % NUM_LEDS];
      end
    end
    return r;
  endfunction

  function automatic logic [BOARD_OUT_W-1:0] board_out(
    input logic [NUM_BOARD_LEDS-1:0] b
  );
    logic [BOARD_OUT_W-1:0] r;
    r = '0;
    for (int i = 0; i < BOARD_OUT_W; i++) begin
      if (i < NUM_BOARD_LEDS) begin
        r[i] = b[i % NUM_BOARD_LEDS];
      end
    end
    return r;
  endfunction

endpackage

// ----- design/lps_if.sv -----
// Valid/ready channel interfaces: tick input, LED result and configuration write.
`timescale 1ns / 1ps

interface lps_in_if;
  import lps_pkg::*;
  logic valid;
  logic ready;
  logic mode_press;
  logic board_press;
  modport source (output valid, mode_press, board_press, input ready);
  modport sink   (input valid, mode_press, board_press, output ready);
endinterface

interface lps_out_if;
  import lps_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [PAT_OUT_W-1:0]   pattern_leds;
  logic [BOARD_OUT_W-1:0] board_leds;
  logic [MODE_W-1:0]      current_mode;
  modport source (output valid, pattern_leds, board_leds, current_mode, input ready);
  modport sink   (input valid, pattern_leds, board_leds, current_mode, output ready);
endinterface

interface lps_cfg_if;
  import lps_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [PERIOD_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/lps_scene.sv -----
// One pattern step of the active scene.
`timescale 1ns / 1ps

module lps_scene import lps_pkg::*; (
  input  mode_t              mode,
  input  logic [MOD_W-1:0]   tick_mod,
  input  scene_state_t       cur,
  output scene_state_t       nxt
);

  localparam logic [STEP_W-1:0] LAST = STEP_W'(NUM_LEDS - 1);
  localparam logic [STEP_W-1:0] N    = STEP_W'(NUM_LEDS);

  logic [STEP_W-1:0]   s;
  logic [STEP_W-1:0]   s_bounce;
  logic [NUM_LEDS-1:0] ends;

  assign s    = (cur.step >= N) ? '0 : cur.step;
  assign ends = one_led('0) | one_led(LAST);

  always_comb begin
    if (cur.fwd) begin
      s_bounce = s + 1'b1;
    end else if (s == '0) begin
      s_bounce = LAST;
    end else begin
      s_bounce = s - 1'b1;
    end
  end

  always_comb begin
    nxt = cur;
    case (mode)
      MODE_SYNC: begin
        nxt.pattern = ~cur.pattern;
      end
      MODE_CHASE: begin
        nxt.pattern = one_led(s);
        nxt.step    = (s == LAST) ? '0 : s + 1'b1;
      end
      MODE_BOUNCE: begin
        nxt.pattern = one_led(s);
        nxt.step    = s_bounce;
        if (s_bounce == LAST || s_bounce == '0) begin
          nxt.fwd = ~cur.fwd;
        end
      end
      MODE_STREAK: begin
        nxt.pattern = (cur.step < N) ? (cur.pattern | one_led(cur.step)) : '0;
        nxt.step    = (cur.step >= N) ? '0 : cur.step + 1'b1;
      end
      MODE_ALARM: begin
        nxt.pattern = (cur.pattern ^ ends) & ends;
      end
      default: begin
        nxt.pattern = one_led(STEP_W'(tick_mod));
      end
    endcase
  end

endmodule

// ----- design/led_pattern_sequencer_unit.sv -----
// Top level of the LED pattern sequencer: tick handling, countdown and result register.
`timescale 1ns / 1ps

// Each transfer on the input channel is one millisecond tick with two
// debounced press flags, and each one yields exactly one result transfer that
// shows the LED state after that tick. The state registers double as the
// result register, so the result of a tick is valid in the cycle after it is
// taken, and a new tick is taken in every cycle in which the result slot is
// empty or is being taken at the same edge, so the sustained rate is one tick
// per clock. The six period registers are written through the configuration
// channel, which is always ready; indexes above the last register are
// dropped. A period of zero behaves as one (a step on every tick). A mode
// press clears step and pattern but leaves the running countdown alone.
module led_pattern_sequencer_unit import lps_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  lps_in_if.sink    in_ch,
  lps_out_if.source out_ch,
  lps_cfg_if.sink   cfg_ch
);

  // Architectural state, held until the next tick transfer
  mode_t                     mode_r,    mode_nxt;
  scene_state_t              scene_r,   scene_nxt;
  logic [NUM_BOARD_LEDS-1:0] board_r,   board_nxt;
  logic [PERIOD_W-1:0]       count_r,   count_nxt;
  logic [TICK_W-1:0]         tick_r,    tick_nxt;
  logic [MOD_W-1:0]          tick_mod_r, tick_mod_nxt;
  logic                      out_valid_r;
  logic [PERIOD_W-1:0]       periods_r [NUM_MODES];

  logic                in_xfer;
  mode_t               mode_cur;
  scene_state_t        scene_pre;
  scene_state_t        scene_step;
  logic                fire;
  logic [PERIOD_W-1:0] period_sel;

  // Take a tick whenever the result slot is free or drains this cycle
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  // Free-running tick count; keep its residue mod NUM_LEDS alongside so the
  // random scene needs no divider. The residue restarts when the count wraps.
  assign tick_nxt = tick_r + 1'b1;
  always_comb begin
    if (tick_r == '1 || tick_mod_r == MOD_W'(NUM_LEDS - 1)) begin
      tick_mod_nxt = '0;
    end else begin
      tick_mod_nxt = tick_mod_r + 1'b1;
    end
  end

  // Mode press: advance the scene, restart step and pattern, go forward
  assign mode_cur = (mode_r >= MODE_W'(NUM_MODES)) ? MODE_SYNC : mode_r;
  always_comb begin
    mode_nxt  = mode_cur;
    scene_pre = scene_r;
    if (in_ch.mode_press) begin
      mode_nxt          = (mode_cur == MODE_RANDOM) ? MODE_SYNC : mode_t'(mode_cur + 1'b1);
      scene_pre.step    = '0;
      scene_pre.fwd     = 1'b1;
      scene_pre.pattern = '0;
    end
  end

  // Board press: toggle every board LED
  assign board_nxt = in_ch.board_press ? ~board_r : board_r;

  lps_scene u_scene (
    .mode     (mode_nxt),
    .tick_mod (tick_mod_nxt),
    .cur      (scene_pre),
    .nxt      (scene_step)
  );

  // Countdown: fire at one or below, then reload from the new mode's period
  assign fire       = (count_r <= PERIOD_W'(1));
  assign period_sel = periods_r[mode_nxt];
  assign scene_nxt  = fire ? scene_step : scene_pre;
  always_comb begin
    if (!fire) begin
      count_nxt = count_r - 1'b1;
    end else if (period_sel == '0) begin
      count_nxt = PERIOD_W'(1);
    end else begin
      count_nxt = period_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_SYNC;
      scene_r     <= '{step: '0, fwd: 1'b1, pattern: '0};
      board_r     <= '0;
      count_r     <= PERIOD_RESET[REG_PERIOD_SYNC];
      tick_r      <= '0;
      tick_mod_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        mode_r      <= mode_nxt;
        scene_r     <= scene_nxt;
        board_r     <= board_nxt;
        count_r     <= count_nxt;
        tick_r      <= tick_nxt;
        tick_mod_r  <= tick_mod_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Period registers; drop writes past the last register
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_MODES; i++) begin
        periods_r[i] <= PERIOD_RESET[i];
      end
    end else if (cfg_ch.valid && cfg_ch.index <= REG_PERIOD_RANDOM) begin
      periods_r[cfg_ch.index] <= cfg_ch.data;
    end
  end

  // Result: the state after the last accepted tick
  assign out_ch.valid        = out_valid_r;
  assign out_ch.pattern_leds = pattern_out(scene_r.pattern);
  assign out_ch.board_leds   = board_out(board_r);
  assign out_ch.current_mode = mode_r;

  // The countdown reloads to at least one, so it never sits at zero
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != '0)
    else $error("step countdown reached zero");

  // Every accepted tick leaves a result waiting
  a_xfer_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> out_valid_r)
    else $error("accepted tick produced no result");

  // A mode press always moves to another mode
  a_mode_press: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_ch.mode_press) |=> (mode_r != $past(mode_r)))
    else $error("mode press did not change mode");

  // A board press inverts every board LED
  a_board_press: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_ch.board_press) |=> (board_r == ~$past(board_r)))
    else $error("board press did not toggle board LEDs");

  // The tick residue stays below the LED count
  a_tick_mod: assert property (@(posedge clk) disable iff (!rst_n)
    tick_mod_r <= MOD_W'(NUM_LEDS - 1))
    else $error("tick residue out of range");

endmodule
